/* sv/sct_pkg.sv */
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants for the scope capture trigger
// Payload structs, configuration register map, reset values and sizes.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int SAMPLE_BITS          = 16;
    localparam int BUFFER_DEPTH_DEFAULT = 512;
    localparam int INDEX_BITS           = 9;
    localparam int CFG_DATA_BITS        = 16;
    localparam int CFG_INDEX_BITS       = 3;
    localparam int COUNT_BITS           = 16;
    localparam int HYST_BITS            = 15;

    // Register map, in configuration index order
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DECIM_COUNT   = 3'd0,
        CFG_TRIGGER_LEVEL = 3'd1,
        CFG_HYSTERESIS    = 3'd2,
        CFG_EXTERNAL_MODE = 3'd3,
        CFG_HOLDOFF_COUNT = 3'd4
    } cfg_index_t;

    localparam logic [COUNT_BITS-1:0]         DECIM_COUNT_RESET   = 16'd3;
    localparam logic signed [SAMPLE_BITS-1:0] TRIGGER_LEVEL_RESET = 16'sd0;
    localparam logic [HYST_BITS-1:0]          HYSTERESIS_RESET    = 15'd320;
    localparam logic                          EXTERNAL_MODE_RESET = 1'b0;
    localparam logic [COUNT_BITS-1:0]         HOLDOFF_COUNT_RESET = 16'd4800;

    typedef struct packed {
        logic [COUNT_BITS-1:0]         decim_count;
        logic signed [SAMPLE_BITS-1:0] trigger_level;
        logic [HYST_BITS-1:0]          hysteresis;
        logic                          external_mode;
        logic [COUNT_BITS-1:0]         holdoff_count;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] signal_sample;
        logic                          signal_connected;
        logic signed [SAMPLE_BITS-1:0] trig_sample;
        logic                          trig_connected;
    } sample_t;

    typedef struct packed {
        logic                          capture_valid;
        logic [INDEX_BITS-1:0]         capture_index;
        logic signed [SAMPLE_BITS-1:0] capture_value;
        logic                          sweep_restart;
        logic                          waiting_trigger;
        logic                          channel_active;
    } result_t;

endpackage

/* sv/sct_cfg.sv */
// ----------------------------------------------------------------------------
// sct_cfg: configuration register file
// Holds the five trigger and capture settings, written through a plain port.
// ----------------------------------------------------------------------------
module sct_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [sct_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [sct_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    output sct_pkg::cfg_t                         cfg
);

    sct_pkg::cfg_t cfg_reg;
    sct_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (sct_pkg::cfg_index_t'(cfg_index))
                sct_pkg::CFG_DECIM_COUNT:
                    cfg_next.decim_count = cfg_data;
                sct_pkg::CFG_TRIGGER_LEVEL:
                    cfg_next.trigger_level = $signed(cfg_data);
                sct_pkg::CFG_HYSTERESIS:
                    cfg_next.hysteresis = cfg_data[sct_pkg::HYST_BITS-1:0];
                sct_pkg::CFG_EXTERNAL_MODE:
                    cfg_next.external_mode = cfg_data[0];
                sct_pkg::CFG_HOLDOFF_COUNT:
                    cfg_next.holdoff_count = cfg_data;
                default:
                    cfg_next = cfg_reg;   // ignore writes past the map
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decim_count   <= sct_pkg::DECIM_COUNT_RESET;
            cfg_reg.trigger_level <= sct_pkg::TRIGGER_LEVEL_RESET;
            cfg_reg.hysteresis    <= sct_pkg::HYSTERESIS_RESET;
            cfg_reg.external_mode <= sct_pkg::EXTERNAL_MODE_RESET;
            cfg_reg.holdoff_count <= sct_pkg::HOLDOFF_COUNT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/sct_core.sv */
// ----------------------------------------------------------------------------
// sct_core: sweep capture and trigger state
// Decimates samples into the sweep, then runs the Schmitt trigger and holdoff.
// ----------------------------------------------------------------------------
module sct_core #(
    parameter int BUFFER_DEPTH = sct_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  sct_pkg::cfg_t     cfg,
    input  sct_pkg::sample_t  sample,
    output sct_pkg::result_t  result_next
);

    localparam int POS_BITS = $clog2(BUFFER_DEPTH + 1);
    localparam int CB       = sct_pkg::COUNT_BITS;
    localparam int SB       = sct_pkg::SAMPLE_BITS;
    localparam int IB       = sct_pkg::INDEX_BITS;
    localparam int THR_BITS = SB + 2;
    localparam logic [POS_BITS-1:0] DEPTH_POS = POS_BITS'(BUFFER_DEPTH);

    logic [POS_BITS-1:0] sweep_position_reg, sweep_position_next;
    logic [CB-1:0]       frame_counter_reg, frame_counter_next;
    logic                schmitt_high_reg, schmitt_high_next;

    logic [CB:0]                 frame_inc;
    logic [CB-1:0]               frame_wait;
    logic [POS_BITS+IB-1:0]      pos_wide;
    logic signed [THR_BITS-1:0]  low_threshold;
    logic signed [THR_BITS-1:0]  gate_ext;
    logic signed [THR_BITS-1:0]  level_ext;
    logic                        full;
    logic                        fired;

    always_comb
    begin
        sweep_position_next = sweep_position_reg;
        frame_counter_next  = frame_counter_reg;
        schmitt_high_next   = schmitt_high_reg;
        fired               = 1'b0;
        frame_wait          = '0;

        result_next.capture_valid   = 1'b0;
        result_next.capture_index   = '0;
        result_next.capture_value   = '0;
        result_next.sweep_restart   = 1'b0;
        result_next.channel_active  = sample.signal_connected;

        pos_wide  = {{IB{1'b0}}, sweep_position_reg};
        frame_inc = {1'b0, frame_counter_reg} + {{CB{1'b0}}, 1'b1};

        level_ext     = THR_BITS'(cfg.trigger_level);
        low_threshold = level_ext - $signed({3'b000, cfg.hysteresis});
        gate_ext      = cfg.external_mode ? THR_BITS'(sample.trig_sample)
                                          : THR_BITS'(sample.signal_sample);

        // Capture phase: keep one sample in every decim_count+1
        if (sweep_position_reg < DEPTH_POS)
        begin
            if (frame_inc > {1'b0, cfg.decim_count})
            begin
                frame_counter_next          = '0;
                result_next.capture_valid   = 1'b1;
                result_next.capture_index   = pos_wide[IB-1:0];
                result_next.capture_value   = sample.signal_sample;
                sweep_position_next         = sweep_position_reg + POS_BITS'(1);
            end
            else
            begin
                frame_counter_next = frame_inc[CB-1:0];
            end
        end

        full = (sweep_position_next >= DEPTH_POS);

        // Wait phase: may run in the same transaction that filled the sweep
        if (full)
        begin
            if (cfg.external_mode && !sample.trig_connected)
            begin
                result_next.sweep_restart = 1'b1;
            end
            else
            begin
                if (frame_counter_next == '0)
                    schmitt_high_next = 1'b1;   // re-arm high when waiting begins
                frame_wait = frame_counter_next + CB'(1);
                if (schmitt_high_next)
                begin
                    if (gate_ext <= low_threshold)
                        schmitt_high_next = 1'b0;
                end
                else if (gate_ext >= level_ext)
                begin
                    schmitt_high_next = 1'b1;
                    fired             = 1'b1;
                end
                frame_counter_next = frame_wait;
                if (fired || (frame_wait >= cfg.holdoff_count))
                    result_next.sweep_restart = 1'b1;
            end
            if (result_next.sweep_restart)
            begin
                sweep_position_next = '0;
                frame_counter_next  = '0;
            end
        end

        result_next.waiting_trigger = full && !result_next.sweep_restart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_position_reg <= '0;
            frame_counter_reg  <= '0;
            schmitt_high_reg   <= 1'b1;
        end
        else if (advance)
        begin
            sweep_position_reg <= sweep_position_next;
            frame_counter_reg  <= frame_counter_next;
            schmitt_high_reg   <= schmitt_high_next;
        end
    end

endmodule

/* sv/sct_outreg.sv */
// ----------------------------------------------------------------------------
// sct_outreg: result register
// Holds one result transaction until taken; reloads in the same cycle.
// ----------------------------------------------------------------------------
module sct_outreg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sct_pkg::result_t  data_next,
    input  logic              result_ready,
    output logic              can_load,
    output logic              result_valid,
    output sct_pkg::result_t  result
);

    logic             valid_reg, valid_next;
    sct_pkg::result_t data_reg;

    assign can_load   = !valid_reg || result_ready;
    assign valid_next = load || (valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

/* sv/scope_capture_trigger.sv */
// ----------------------------------------------------------------------------
// scope_capture_trigger: oscilloscope sweep capture with Schmitt trigger
// Top level: configuration registers, capture/trigger core, result register.
// ----------------------------------------------------------------------------
// One sample transaction is accepted per clock unless an untaken result stalls it,
// and yields exactly one registered result; throughput is one per cycle, set by
// the single update of the sweep position, frame counter and trigger state.
// While the result register holds a transaction that is not taken, sample_ready
// stays low. The block keeps one sample in every decim_count+1 and reports each
// sweep write as capture_index/capture_value until BUFFER_DEPTH are held, then
// waits for a rising Schmitt crossing of trigger_level (re-arm at
// trigger_level - hysteresis) on the signal or, in external mode, on the
// trigger input. It restarts on that crossing, after holdoff_count waiting
// samples, or at once in external mode with no trigger connected. Write the
// configuration only while no transaction is in flight.
// ----------------------------------------------------------------------------
module scope_capture_trigger #(
    parameter int BUFFER_DEPTH = sct_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  sct_pkg::sample_t                    sample,
    // result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output sct_pkg::result_t                    result,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [sct_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sct_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    sct_pkg::cfg_t    cfg;
    sct_pkg::result_t result_next;
    logic             can_load;
    logic             advance;

    // Advance state exactly when a sample transaction is accepted
    assign sample_ready = can_load;
    assign advance      = sample_valid && can_load;

    sct_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sct_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .cfg         (cfg),
        .sample      (sample),
        .result_next (result_next)
    );

    // Result register parts the two sides so a new sample enters while
    // the previous result is being taken
    sct_outreg u_outreg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .data_next    (result_next),
        .result_ready (result_ready),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // Every accepted sample produces a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> result_valid)
        else $error("accepted sample did not produce a result");

    // A restart leaves the sweep empty, so it never reports waiting
    a_restart_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.sweep_restart && result.waiting_trigger))
        else $error("restart and waiting_trigger both set");

    // Index and value are zero unless a sample was written
    a_idle_capture_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.capture_valid)
            |-> (result.capture_index == '0 && result.capture_value == '0))
        else $error("capture fields set without capture_valid");
`endif

endmodule

/* sim/tb_scope_capture_trigger.sv */
// ----------------------------------------------------------------------------
// tb_scope_capture_trigger: self-checking bench for the scope capture trigger
// Drives sample transactions through the valid/ready channel under several
// register settings. A scoreboard class predicts each result transaction
// (sweep writes, Schmitt trigger, holdoff and restarts) and compares every
// field in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_scope_capture_trigger;
    import sct_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int BUF_DEPTH      = BUFFER_DEPTH_DEFAULT;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 242;
    localparam int LONG_HOLD      = 64;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TIMEOUT_CYCLES = 400000;

    // ------------------------------------------------------------------------
    // Sweep predictor and ordered store of expected result transactions
    // ------------------------------------------------------------------------
    class capture_scoreboard;
        cfg_t                  cfg;
        int unsigned           sweep_pos;   // 0..BUF_DEPTH, BUF_DEPTH means full
        logic [COUNT_BITS-1:0] frame_cnt;   // decimation or holdoff count
        bit                    armed_high;  // Schmitt state
        result_t               pending[$];
        int                    errors;

        function new();
            cfg.decim_count   = DECIM_COUNT_RESET;
            cfg.trigger_level = TRIGGER_LEVEL_RESET;
            cfg.hysteresis    = HYSTERESIS_RESET;
            cfg.external_mode = EXTERNAL_MODE_RESET;
            cfg.holdoff_count = HOLDOFF_COUNT_RESET;
            sweep_pos  = 0;
            frame_cnt  = '0;
            armed_high = 1'b1;
            errors     = 0;
        endfunction

        function void apply_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_DECIM_COUNT:   cfg.decim_count   = data;
                CFG_TRIGGER_LEVEL: cfg.trigger_level = data;
                CFG_HYSTERESIS:    cfg.hysteresis    = data[HYST_BITS-1:0];
                CFG_EXTERNAL_MODE: cfg.external_mode = data[0];
                CFG_HOLDOFF_COUNT: cfg.holdoff_count = data;
                default: ;
            endcase
        endfunction

        // Work out the result of one accepted sample transaction
        function void note_sample(sample_t s);
            result_t                       r;
            logic signed [SAMPLE_BITS-1:0] gate;
            int                            rearm_at;
            int unsigned                   nxt;
            bit                            fired;
            r = '0;
            r.channel_active = s.signal_connected;
            // Filling: keep one sample in decim_count+1
            if (sweep_pos < BUF_DEPTH)
            begin
                nxt = frame_cnt + 1;
                if (nxt > cfg.decim_count)
                begin
                    frame_cnt       = '0;
                    r.capture_valid = 1'b1;
                    r.capture_index = sweep_pos[INDEX_BITS-1:0];
                    r.capture_value = s.signal_sample;
                    sweep_pos++;
                end
                else
                begin
                    frame_cnt = nxt[COUNT_BITS-1:0];
                end
            end
            // Full: wait for trigger, may run in the same transaction as the last write
            if (sweep_pos >= BUF_DEPTH)
            begin
                if (cfg.external_mode && !s.trig_connected)
                begin
                    sweep_pos       = 0;
                    frame_cnt       = '0;
                    r.sweep_restart = 1'b1;
                end
                else
                begin
                    gate  = cfg.external_mode ? s.trig_sample : s.signal_sample;
                    fired = 1'b0;
                    // re-arm high as waiting begins
                    if (frame_cnt == '0)
                        armed_high = 1'b1;
                    frame_cnt = frame_cnt + 1'b1;
                    rearm_at  = int'(cfg.trigger_level) - int'(cfg.hysteresis);
                    if (armed_high)
                    begin
                        if (int'(gate) <= rearm_at)
                            armed_high = 1'b0;
                    end
                    else if (gate >= cfg.trigger_level)
                    begin
                        armed_high = 1'b1;
                        fired      = 1'b1;
                    end
                    if (fired || frame_cnt >= cfg.holdoff_count)
                    begin
                        sweep_pos       = 0;
                        frame_cnt       = '0;
                        r.sweep_restart = 1'b1;
                    end
                end
            end
            r.waiting_trigger = (sweep_pos >= BUF_DEPTH);
            pending.push_back(r);
        endfunction

        function void compare_field(string field, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("capture_valid",   32'(want.capture_valid),
                          32'(got.capture_valid));
            compare_field("capture_index",   32'(want.capture_index),
                          32'(got.capture_index));
            compare_field("capture_value",   32'(want.capture_value),
                          32'(got.capture_value));
            compare_field("sweep_restart",   32'(want.sweep_restart),
                          32'(got.sweep_restart));
            compare_field("waiting_trigger", 32'(want.waiting_trigger),
                          32'(got.waiting_trigger));
            compare_field("channel_active",  32'(want.channel_active),
                          32'(got.channel_active));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block hookup
    // ------------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n;
    logic                      sample_valid;
    logic                      sample_ready;
    sample_t                   sample_bus;
    logic                      result_valid;
    logic                      result_ready;
    result_t                   result_bus;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    scope_capture_trigger DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    capture_scoreboard sb = new();

    // Idle rates in percent, changed per phase by the stimulus
    int tx_idle_pct   = 16;
    int rx_idle_pct   = 81;
    int trig_conn_pct = 50;
    bit long_hold     = 1'b0;   // ask the receiver for one long stall

    // Waveform used to steer the trigger source across both thresholds
    cfg_t cur_cfg;
    int   wave_val;
    int   wave_dir;
    int   wave_step;
    int   wave_lo;
    int   wave_hi;

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Watch both channels; sample values as they stood before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
                sb.note_sample(sample_bus);
            if (result_valid && result_ready)
                sb.check_result(result_bus);
        end
    end

    // Result side: random back-pressure plus one long stall on request
    initial
    begin : result_sink
        int held;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                result_ready <= 1'b0;
                // hold off while the sender keeps offering, so the block backs up
                for (held = 0; held < LONG_HOLD; held++)
                    @(posedge clk);
            end
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic sample_t mk_sample(int sig, bit sig_conn, int trg, bit trg_conn);
        sample_t s;
        s.signal_sample    = sig[SAMPLE_BITS-1:0];
        s.signal_connected = sig_conn;
        s.trig_sample      = trg[SAMPLE_BITS-1:0];
        s.trig_connected   = trg_conn;
        return s;
    endfunction

    // Mostly a triangle across the thresholds on the trigger source, some noise
    function automatic sample_t next_sample();
        sample_t s;
        int      v;
        s.signal_sample    = SAMPLE_BITS'($urandom_range(65535));
        s.trig_sample      = SAMPLE_BITS'($urandom_range(65535));
        s.signal_connected = 1'($urandom_range(1));
        s.trig_connected   = ($urandom_range(99) < trig_conn_pct);
        if ($urandom_range(99) < 80)
        begin
            wave_val += wave_dir * wave_step;
            if (wave_val >= wave_hi)
                wave_dir = -1;
            else if (wave_val <= wave_lo)
                wave_dir = 1;
            v = wave_val;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            if (cur_cfg.external_mode)
                s.trig_sample = v[SAMPLE_BITS-1:0];
            else
                s.signal_sample = v[SAMPLE_BITS-1:0];
        end
        return s;
    endfunction

    // Offer one sample transaction and return at the edge that takes it
    task automatic send_sample(input sample_t s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_bus   <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the extra edge keeps writes apart
    task automatic set_register(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.apply_register(idx, data);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        cfg_t c;
        int   ph;
        int   k;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample_bus   <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings keep one in four: only the last of these is written
        send_sample(mk_sample(32767, 1'b1, -32768, 1'b1));
        send_sample(mk_sample(-32768, 1'b0, 32767, 1'b0));
        send_sample(mk_sample(0, 1'b1, 0, 1'b1));
        send_sample(mk_sample(-1, 1'b1, -1, 1'b0));
        // Largest decimation: the count only climbs
        drain_results();
        set_register(CFG_DECIM_COUNT, 16'hffff);
        send_sample(mk_sample(21845, 1'b1, -21846, 1'b0));
        send_sample(mk_sample(-21846, 1'b0, 21845, 1'b1));
        send_sample(mk_sample(12345, 1'b1, -12345, 1'b1));
        // Lowered decimation below the running count keeps the next sample,
        // and a disconnected signal is still written as given
        drain_results();
        set_register(CFG_DECIM_COUNT, 16'h0000);
        send_sample(mk_sample(-12345, 1'b0, 777, 1'b1));
        send_sample(mk_sample(32767, 1'b0, -32768, 1'b0));
        send_sample(mk_sample(-32768, 1'b1, 32767, 1'b1));

        // Random phases; the sweep carries over, so waiting lands in
        // whichever settings are active when it fills
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0: c = '{16'd0, 16'sd2000, 15'd600, 1'b0, 16'd4800};
                1: c = '{16'd0, -16'sd32768, 15'd0, 1'b0, 16'd65535};
                2: c = '{16'd0, 16'sd1000, 15'd300, 1'b0, 16'd120};
                3: c = '{16'd0, 16'sd32767, 15'd32767, 1'b1, 16'd150};
                4: c = '{16'd0, -16'sd500, 15'd0, 1'b1, 16'd0};
                5: c = '{16'd1, 16'sd0, 15'd320, 1'b1, 16'd1};
                6: c = '{16'd0, 16'($urandom_range(65535)), 15'($urandom_range(4000)),
                         1'b0, 16'd65535};
                default: c = '{16'($urandom_range(2)), 16'($urandom_range(65535)),
                               15'($urandom_range(32767)), 1'b1, 16'd300};
            endcase
            set_register(CFG_DECIM_COUNT,   c.decim_count);
            set_register(CFG_TRIGGER_LEVEL, c.trigger_level);
            set_register(CFG_HYSTERESIS,    {1'b0, c.hysteresis});
            set_register(CFG_EXTERNAL_MODE, {15'd0, c.external_mode});
            set_register(CFG_HOLDOFF_COUNT, c.holdoff_count);
            cur_cfg = c;

            // sender idles lightly first, then the receiver, then neither
            tx_idle_pct   = (ph < 3) ? 16 : (ph < 6) ? 81 : 0;
            rx_idle_pct   = (ph < 3) ? 81 : (ph < 6) ? 16 : 0;
            trig_conn_pct = (c.external_mode && ph != 5) ? 95 : 50;

            wave_hi   = int'(c.trigger_level) + 200;
            wave_lo   = int'(c.trigger_level) - int'(c.hysteresis) - 200;
            wave_val  = wave_hi;
            wave_dir  = -1;
            wave_step = (wave_hi - wave_lo) / int'($urandom_range(3, 40)) + 1;

            if (ph == 6)
                long_hold = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++)
                send_sample(next_sample());
        end
        drain_results();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("scope_capture_trigger test passed");
        else
            $display("scope_capture_trigger test failed");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("scope_capture_trigger test failed");
        $finish;
    end

endmodule
